>>> rtl/lpi_pkg.sv
`default_nettype none

package lpi_pkg;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        REG_PLANE_X  = 3'd0,
        REG_PLANE_Y  = 3'd1,
        REG_PLANE_Z  = 3'd2,
        REG_NORMAL_X = 3'd3,
        REG_NORMAL_Y = 3'd4,
        REG_NORMAL_Z = 3'd5
    } reg_idx_t;

    // Quotient bits produced by the divider; larger quotients are clamped.
    localparam int DIV_BITS = 41;

    // Pipeline stage numbers.
    localparam int ST_IN      = 0;
    localparam int ST_PROD    = 1;
    localparam int ST_SUM     = 2;
    localparam int ST_ABS     = 3;
    localparam int ST_MUL     = 4;
    localparam int ST_ADD     = 5;
    localparam int ST_OVF     = 6;
    localparam int ST_DIV     = 7;
    localparam int ST_OUT     = ST_DIV + DIV_BITS;
    localparam int NUM_STAGES = ST_OUT + 1;

    // Operands handed to one coordinate lane.
    typedef struct packed {
        logic signed [31:0] s;      // start coordinate
        logic        [31:0] ad;     // magnitude of end - start
        logic               neg;    // sign of the offset
        logic        [64:0] anum;   // magnitude of the numerator
        logic        [64:0] aden;   // magnitude of the denominator
        logic               zero;   // denominator is zero
    } lane_in_t;

    // Result of one coordinate lane.
    typedef struct packed {
        logic               hit;
        logic signed [31:0] coord;
        logic               sat;
    } lane_res_t;

endpackage

`default_nettype wire

>>> rtl/lpi_lane.sv
`default_nettype none

module lpi_lane
    import lpi_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic [NUM_STAGES-1:0] en,
    input  wire lane_in_t              lane_in,
    output lane_res_t                  lane_out
);

    localparam logic [DIV_BITS-1:0] QLIM = DIV_BITS'(1) << (DIV_BITS - 1);

    // Multiply stage: the 65-bit numerator is split into two partial products.
    logic        [64:0] plo_reg;
    logic        [63:0] phi_reg;
    lane_in_t           mul_reg;

    always_ff @(posedge clk)
    begin
        if (en[ST_MUL])
        begin
            plo_reg <= lane_in.anum[32:0] * lane_in.ad;
            phi_reg <= lane_in.anum[64:33] * lane_in.ad;
            mul_reg <= lane_in;
        end
    end

    logic [96:0] prod_reg;
    lane_in_t    add_reg;

    always_ff @(posedge clk)
    begin
        if (en[ST_ADD])
        begin
            prod_reg <= {32'd0, plo_reg} + {phi_reg, 33'd0};
            add_reg  <= mul_reg;
        end
    end

    // Divider registers; entry 0 is the overflow check stage.
    logic        [96:0]         r_reg   [DIV_BITS+1];
    logic        [DIV_BITS-1:0] q_reg   [DIV_BITS+1];
    logic        [64:0]         d_reg   [DIV_BITS+1];
    logic signed [31:0]         s_reg   [DIV_BITS+1];
    logic                       neg_reg [DIV_BITS+1];
    logic                       ovf_reg [DIV_BITS+1];
    logic                       zero_reg[DIV_BITS+1];

    always_ff @(posedge clk)
    begin
        if (en[ST_OVF])
        begin
            r_reg[0]    <= prod_reg;
            q_reg[0]    <= '0;
            d_reg[0]    <= add_reg.aden;
            s_reg[0]    <= add_reg.s;
            neg_reg[0]  <= add_reg.neg;
            zero_reg[0] <= add_reg.zero;
            ovf_reg[0]  <= {9'd0, prod_reg} >= ({41'd0, add_reg.aden} << DIV_BITS);
        end
    end

    // One restoring step per stage, most significant quotient bit first.
    for (genvar j = 0; j < DIV_BITS; j++)
    begin : g_div
        localparam int K = DIV_BITS - 1 - j;
        logic [105:0] dsh;
        logic         ge;

        assign dsh = {41'd0, d_reg[j]} << K;
        assign ge  = {9'd0, r_reg[j]} >= dsh;

        always_ff @(posedge clk)
        begin
            if (en[ST_DIV + j])
            begin
                r_reg[j+1]    <= ge ? r_reg[j] - dsh[96:0] : r_reg[j];
                q_reg[j+1]    <= q_reg[j] | (DIV_BITS'(ge) << K);
                d_reg[j+1]    <= d_reg[j];
                s_reg[j+1]    <= s_reg[j];
                neg_reg[j+1]  <= neg_reg[j];
                ovf_reg[j+1]  <= ovf_reg[j];
                zero_reg[j+1] <= zero_reg[j];
            end
        end
    end

    // Clamp the quotient, apply its sign, add the start and saturate.
    logic        [DIV_BITS-1:0] qm;
    logic signed [41:0]         off;
    logic signed [41:0]         sum;
    logic                       pos_ovf;
    logic                       neg_ovf;
    lane_res_t                  res_next;

    always_comb
    begin
        qm  = (ovf_reg[DIV_BITS] || q_reg[DIV_BITS] > QLIM) ? QLIM : q_reg[DIV_BITS];
        off = neg_reg[DIV_BITS] ? 42'sd0 - $signed({1'b0, qm}) : $signed({1'b0, qm});
        sum = $signed({{10{s_reg[DIV_BITS][31]}}, s_reg[DIV_BITS]}) + off;
        pos_ovf = !sum[41] && (|sum[40:31]);
        neg_ovf = sum[41] && !(&sum[40:31]);
        if (zero_reg[DIV_BITS])
        begin
            res_next = '0;
        end
        else
        begin
            res_next.hit   = 1'b1;
            res_next.sat   = pos_ovf || neg_ovf;
            res_next.coord = pos_ovf ? 32'sh7fffffff :
                             neg_ovf ? 32'sh80000000 : sum[31:0];
        end
    end

    lane_res_t res_reg;

    always_ff @(posedge clk)
    begin
        if (en[ST_OUT])
        begin
            res_reg <= res_next;
        end
    end

    assign lane_out = res_reg;

endmodule

`default_nettype wire

>>> rtl/line_plane_intersection.sv
// Channel   Signals                                    Direction
// input     in_valid, in_ready, start_*, end_*         request into the block
// output    out_valid, out_ready, hit, cross_*,        result out of the block
//           saturated
// config    cfg_we, cfg_index, cfg_data                register write, no wait
//
// A request enters every cycle while the output is not stalled; its result passes
// through the 49 register stages, 41 of which form the restoring divider that
// produces one quotient bit per stage.
// Reset clears all stage valid bits and loads the plane registers.
// A stalled output holds only the stages that are full; empty stages keep
// moving, so requests are taken until the pipeline is truly full.
`default_nettype none

module line_plane_intersection
    import lpi_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [31:0]        cfg_data,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic signed [31:0] start_x,
    input  wire logic signed [31:0] start_y,
    input  wire logic signed [31:0] start_z,
    input  wire logic signed [31:0] end_x,
    input  wire logic signed [31:0] end_y,
    input  wire logic signed [31:0] end_z,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic                    hit,
    output logic signed [31:0]      cross_x,
    output logic signed [31:0]      cross_y,
    output logic signed [31:0]      cross_z,
    output logic                    saturated
);

    // The normal resets to 1.0 along z. The fraction width only sets how the
    // coordinate bits are read; the arithmetic below does not depend on it.
    localparam logic signed [31:0] NORMAL_ONE = 32'sd1 <<< FRAC_BITS;

    // Plane registers: point c and normal n.
    logic signed [31:0] pc_reg [3];
    logic signed [31:0] pn_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg[0] <= '0;
            pc_reg[1] <= '0;
            pc_reg[2] <= '0;
            pn_reg[0] <= '0;
            pn_reg[1] <= '0;
            pn_reg[2] <= NORMAL_ONE;
        end
        else if (cfg_we)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_PLANE_X:  pc_reg[0] <= cfg_data;
                REG_PLANE_Y:  pc_reg[1] <= cfg_data;
                REG_PLANE_Z:  pc_reg[2] <= cfg_data;
                REG_NORMAL_X: pn_reg[0] <= cfg_data;
                REG_NORMAL_Y: pn_reg[1] <= cfg_data;
                REG_NORMAL_Z: pn_reg[2] <= cfg_data;
                default:      ;
            endcase
        end
    end

    // Stage valid bits. A stage loads when it is empty or its successor loads,
    // so bubbles collapse while the output is stalled.
    logic [NUM_STAGES-1:0] v_reg;
    logic [NUM_STAGES-1:0] en;

    always_comb
    begin
        en[NUM_STAGES-1] = !v_reg[NUM_STAGES-1] || out_ready;
        for (int k = NUM_STAGES - 2; k >= 0; k--)
        begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < NUM_STAGES; k++)
            begin
                if (en[k])
                begin
                    v_reg[k] <= (k == 0) ? in_valid : v_reg[(k == 0) ? 0 : k - 1];
                end
            end
        end
    end

    assign in_ready  = en[ST_IN];
    assign out_valid = v_reg[ST_OUT];

    logic signed [31:0] s_in [3];
    logic signed [31:0] e_in [3];

    assign s_in[0] = start_x;
    assign s_in[1] = start_y;
    assign s_in[2] = start_z;
    assign e_in[0] = end_x;
    assign e_in[1] = end_y;
    assign e_in[2] = end_z;

    // Front end: differences, products with the normal, dot-product sums,
    // then magnitudes for the unsigned divider.
    logic signed [31:0] s0_reg [3];
    logic signed [32:0] cs_reg [3];
    logic signed [32:0] d0_reg [3];
    logic signed [31:0] s1_reg [3];
    logic signed [32:0] d1_reg [3];
    logic signed [64:0] pcn_reg[3];
    logic signed [64:0] pdn_reg[3];
    logic signed [31:0] s2_reg [3];
    logic signed [32:0] d2_reg [3];
    logic signed [66:0] num_reg;
    logic signed [66:0] den_reg;
    lane_in_t           lane_in_reg[3];
    lane_res_t          lane_out[3];

    logic signed [66:0] num_next;
    logic signed [66:0] den_next;
    logic signed [66:0] anum_w;
    logic signed [66:0] aden_w;

    always_comb
    begin
        num_next = {{2{pcn_reg[0][64]}}, pcn_reg[0]} + {{2{pcn_reg[1][64]}}, pcn_reg[1]}
                 + {{2{pcn_reg[2][64]}}, pcn_reg[2]};
        den_next = {{2{pdn_reg[0][64]}}, pdn_reg[0]} + {{2{pdn_reg[1][64]}}, pdn_reg[1]}
                 + {{2{pdn_reg[2][64]}}, pdn_reg[2]};
        anum_w   = num_reg[66] ? 67'sd0 - num_reg : num_reg;
        aden_w   = den_reg[66] ? 67'sd0 - den_reg : den_reg;
    end

    for (genvar i = 0; i < 3; i++)
    begin : g_front
        logic signed [32:0] ad_w;

        assign ad_w = d2_reg[i][32] ? 33'sd0 - d2_reg[i] : d2_reg[i];

        always_ff @(posedge clk)
        begin
            if (en[ST_IN])
            begin
                s0_reg[i] <= s_in[i];
                cs_reg[i] <= {pc_reg[i][31], pc_reg[i]} - {s_in[i][31], s_in[i]};
                d0_reg[i] <= {e_in[i][31], e_in[i]} - {s_in[i][31], s_in[i]};
            end
            if (en[ST_PROD])
            begin
                s1_reg[i]  <= s0_reg[i];
                d1_reg[i]  <= d0_reg[i];
                pcn_reg[i] <= cs_reg[i] * pn_reg[i];
                pdn_reg[i] <= d0_reg[i] * pn_reg[i];
            end
            if (en[ST_SUM])
            begin
                s2_reg[i] <= s1_reg[i];
                d2_reg[i] <= d1_reg[i];
            end
            if (en[ST_ABS])
            begin
                lane_in_reg[i].s    <= s2_reg[i];
                lane_in_reg[i].ad   <= ad_w[31:0];
                lane_in_reg[i].neg  <= d2_reg[i][32] ^ num_reg[66] ^ den_reg[66];
                lane_in_reg[i].anum <= anum_w[64:0];
                lane_in_reg[i].aden <= aden_w[64:0];
                lane_in_reg[i].zero <= (den_reg == 67'sd0);
            end
        end

        lpi_lane u_lane
        (
            .clk      (clk),
            .en       (en),
            .lane_in  (lane_in_reg[i]),
            .lane_out (lane_out[i])
        );
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_SUM])
        begin
            num_reg <= num_next;
            den_reg <= den_next;
        end
    end

    assign hit       = lane_out[0].hit;
    assign cross_x   = lane_out[0].coord;
    assign cross_y   = lane_out[1].coord;
    assign cross_z   = lane_out[2].coord;
    assign saturated = lane_out[0].sat | lane_out[1].sat | lane_out[2].sat;

endmodule

`default_nettype wire

>>> rtl/lpi_checker.sv
`default_nettype none

module lpi_checker
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_valid,
    input wire logic               in_ready,
    input wire logic               out_valid,
    input wire logic               out_ready,
    input wire logic               hit,
    input wire logic signed [31:0] cross_x,
    input wire logic signed [31:0] cross_y,
    input wire logic signed [31:0] cross_z,
    input wire logic               saturated
);

    // A stalled result keeps its valid.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // With no result waiting the pipeline cannot be full.
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("request refused with empty output");

    // A parallel line reports all zeros.
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !hit |-> cross_x == 0 && cross_y == 0 && cross_z == 0 && !saturated)
        else $error("parallel result not zero");

    // A clamp leaves at least one coordinate at a range limit.
    a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && saturated |->
            cross_x == 32'sh7fffffff || cross_x == 32'sh80000000 ||
            cross_y == 32'sh7fffffff || cross_y == 32'sh80000000 ||
            cross_z == 32'sh7fffffff || cross_z == 32'sh80000000)
        else $error("saturation flag without a clamped coordinate");

endmodule

bind line_plane_intersection lpi_checker u_chk (.*);

`default_nettype wire
